/* rtl/gclcr_pkg.sv */
`default_nettype none
package gclcr_pkg;

   // line store size: at most LINE_BYTES-1 bytes are held per line
   localparam int LINE_BYTES = 48;
   localparam int HELD_W     = $clog2(LINE_BYTES);

   // queue between front and back, depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_FIELDS_W = 52;
   localparam int RSP_TDATA_W  = 56;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_N     = 8'h4E;

   // result status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_DUP      = 3'd1;
   localparam logic [2:0] STATUS_RESEND   = 3'd2;
   localparam logic [2:0] STATUS_CKSUM    = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   // classified byte passed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_term;
      logic       is_nul;
      logic       is_space;
      logic       is_star;
      logic       is_blank;
      logic       is_digit;
      logic       is_sign;
      logic       is_minus;
      logic       is_n;
      logic       is_a;
   } byte_class_type;

   // decimal field parser phase
   typedef enum logic [3:0] {
      DEC_IDLE   = 4'b0001,
      DEC_SKIP   = 4'b0010,
      DEC_DIGITS = 4'b0100,
      DEC_DONE   = 4'b1000
   } dec_phase_type;

   typedef struct packed {
      dec_phase_type phase;
      logic          set_neg;
      logic          accum;
   } dec_ctl_type;

   // one step of a decimal field parser: blanks, optional sign, digits
   function automatic dec_ctl_type dec_next(dec_phase_type ph, byte_class_type c);
      dec_ctl_type r;
      r.phase   = ph;
      r.set_neg = 1'b0;
      r.accum   = 1'b0;
      case (ph)
         DEC_SKIP: begin
            if (c.is_blank) begin
               r.phase = DEC_SKIP;
            end else if (c.is_sign) begin
               r.phase   = DEC_DIGITS;
               r.set_neg = c.is_minus;
            end else if (c.is_digit) begin
               r.phase = DEC_DIGITS;
               r.accum = 1'b1;
            end else begin
               r.phase = DEC_DONE;
            end
         end
         DEC_DIGITS: begin
            if (c.is_digit) begin
               r.accum = 1'b1;
            end else begin
               r.phase = DEC_DONE;
            end
         end
         DEC_IDLE: r.phase = DEC_IDLE;
         DEC_DONE: r.phase = DEC_DONE;
         default:  r.phase = DEC_IDLE;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/gclcr_front.sv */
`default_nettype none
module gclcr_front (
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [gclcr_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  wire logic                              q_ready,
   output logic                                   q_push,
   output gclcr_pkg::byte_class_type              q_item
);

   logic [7:0] b;

   assign b          = req_tdata[7:0];
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_item.data     = b;
      q_item.is_term  = (b == gclcr_pkg::CH_LF) || (b == gclcr_pkg::CH_CR);
      q_item.is_nul   = (b == gclcr_pkg::CH_NUL);
      q_item.is_space = (b == gclcr_pkg::CH_SPACE);
      q_item.is_star  = (b == gclcr_pkg::CH_STAR);
      q_item.is_blank = (b == gclcr_pkg::CH_SPACE) || (b == gclcr_pkg::CH_TAB) ||
                        (b == gclcr_pkg::CH_VT) || (b == gclcr_pkg::CH_FF) ||
                        (b == gclcr_pkg::CH_LF) || (b == gclcr_pkg::CH_CR);
      q_item.is_digit = (b >= gclcr_pkg::CH_ZERO) && (b <= gclcr_pkg::CH_NINE);
      q_item.is_sign  = (b == gclcr_pkg::CH_PLUS) || (b == gclcr_pkg::CH_MINUS);
      q_item.is_minus = (b == gclcr_pkg::CH_MINUS);
      q_item.is_n     = (b == gclcr_pkg::CH_N);
      q_item.is_a     = (b == gclcr_pkg::CH_A);
   end

endmodule
`default_nettype wire

/* rtl/gclcr_queue.sv */
`default_nettype none
module gclcr_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire gclcr_pkg::byte_class_type push_item,
   output logic                           ready,
   input  wire logic                      pop,
   output logic                           valid,
   output gclcr_pkg::byte_class_type      item
);

   gclcr_pkg::byte_class_type entries_ff [gclcr_pkg::QUEUE_DEPTH];

   logic [gclcr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gclcr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gclcr_pkg::QCNT_W-1:0] count_ff, count_in;

   assign ready = (count_ff != gclcr_pkg::QCNT_W'(gclcr_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign item  = entries_ff[rd_ptr_ff];

   // pointers wrap naturally since depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + gclcr_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + gclcr_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + gclcr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gclcr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/gclcr_back.sv */
`default_nettype none
module gclcr_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire gclcr_pkg::byte_class_type         q_item,
   output logic                                   q_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [gclcr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   // per-line state
   logic [gclcr_pkg::HELD_W-1:0] held_count_ff, held_count_in;
   logic                         text_ended_ff, text_ended_in;
   logic                         star_seen_ff, star_seen_in;
   logic [7:0]                   xor_committed_ff, xor_committed_in;
   logic                         space_run_odd_ff, space_run_odd_in;
   logic [1:0]                   vis_cnt_ff, vis_cnt_in;
   logic                         first_is_a_ff, first_is_a_in;
   logic                         second_digit_ff, second_digit_in;
   logic                         sp_seen_ff, sp_seen_in;
   logic                         cat_taken_ff, cat_taken_in;
   logic [7:0]                   category_ff, category_in;
   gclcr_pkg::dec_phase_type     num_phase_ff, num_phase_in;
   logic                         num_neg_ff, num_neg_in;
   logic [31:0]                  num_acc_ff, num_acc_in;
   gclcr_pkg::dec_phase_type     code_phase_ff, code_phase_in;
   logic                         code_neg_ff, code_neg_in;
   logic [7:0]                   code_acc_ff, code_acc_in;
   gclcr_pkg::dec_phase_type     given_phase_ff, given_phase_in;
   logic                         given_neg_ff, given_neg_in;
   logic [7:0]                   given_acc_ff, given_acc_in;

   // sequence state
   logic [31:0]                  last_number_ff, last_number_in;
   logic                         any_valid_ff, any_valid_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gclcr_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   gclcr_pkg::dec_ctl_type num_ctl, code_ctl, given_ctl;
   logic [3:0]  digit;
   logic [31:0] num_val, expected;
   logic [7:0]  code_val, given_val;
   logic        ack_line, sum_match;
   logic        line_clear, num_arm, code_arm, given_arm;
   logic        res_fire, res_first;
   logic [2:0]  res_status;
   logic [31:0] res_number;
   logic [7:0]  res_category, res_code;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign digit     = q_item.data[3:0];
   assign num_ctl   = gclcr_pkg::dec_next(num_phase_ff, q_item);
   assign code_ctl  = gclcr_pkg::dec_next(code_phase_ff, q_item);
   assign given_ctl = gclcr_pkg::dec_next(given_phase_ff, q_item);

   assign num_val   = num_neg_ff   ? (32'd0 - num_acc_ff)   : num_acc_ff;
   assign code_val  = code_neg_ff  ? (8'd0 - code_acc_ff)   : code_acc_ff;
   assign given_val = given_neg_ff ? (8'd0 - given_acc_ff)  : given_acc_ff;
   assign expected  = last_number_ff + 32'd1;
   assign sum_match = (xor_committed_ff == given_val);
   assign ack_line  = (vis_cnt_ff == 2'd2) && first_is_a_ff && second_digit_ff;

   always_comb begin
      held_count_in    = held_count_ff;
      text_ended_in    = text_ended_ff;
      star_seen_in     = star_seen_ff;
      xor_committed_in = xor_committed_ff;
      space_run_odd_in = space_run_odd_ff;
      vis_cnt_in       = vis_cnt_ff;
      first_is_a_in    = first_is_a_ff;
      second_digit_in  = second_digit_ff;
      sp_seen_in       = sp_seen_ff;
      cat_taken_in     = cat_taken_ff;
      category_in      = category_ff;
      num_phase_in     = num_phase_ff;
      num_neg_in       = num_neg_ff;
      num_acc_in       = num_acc_ff;
      code_phase_in    = code_phase_ff;
      code_neg_in      = code_neg_ff;
      code_acc_in      = code_acc_ff;
      given_phase_in   = given_phase_ff;
      given_neg_in     = given_neg_ff;
      given_acc_in     = given_acc_ff;
      last_number_in   = last_number_ff;
      any_valid_in     = any_valid_ff;
      line_clear       = 1'b0;
      num_arm          = 1'b0;
      code_arm         = 1'b0;
      given_arm        = 1'b0;
      res_fire         = 1'b0;
      res_status       = gclcr_pkg::STATUS_OK;
      res_number       = '0;
      res_category     = '0;
      res_code         = '0;
      res_first        = 1'b0;

      if (q_pop) begin
         if (!q_item.is_term) begin
            if (held_count_ff == gclcr_pkg::HELD_W'(gclcr_pkg::LINE_BYTES - 1)) begin
               // line full: byte dropped, overflow reported
               line_clear = 1'b1;
               res_fire   = 1'b1;
               res_status = gclcr_pkg::STATUS_OVERFLOW;
            end else begin
               held_count_in = held_count_ff + gclcr_pkg::HELD_W'(1);
               if (!text_ended_ff) begin
                  if (q_item.is_nul) begin
                     text_ended_in = 1'b1;
                  end else begin
                     // first two visible chars for acknowledge lines
                     if (vis_cnt_ff == 2'd0) begin
                        first_is_a_in = q_item.is_a;
                        vis_cnt_in    = 2'd1;
                        num_arm       = q_item.is_n;
                     end else if (vis_cnt_ff == 2'd1) begin
                        second_digit_in = q_item.is_digit;
                        vis_cnt_in      = 2'd2;
                     end

                     // category follows the first space, code two after it
                     if (sp_seen_ff && !cat_taken_ff) begin
                        category_in  = q_item.data;
                        cat_taken_in = 1'b1;
                        code_arm     = 1'b1;
                     end else if (!sp_seen_ff && q_item.is_space) begin
                        sp_seen_in = 1'b1;
                     end

                     // checksum with trailing spaces held back
                     if (!star_seen_ff) begin
                        if (q_item.is_star) begin
                           star_seen_in = 1'b1;
                           given_arm    = 1'b1;
                        end else if (q_item.is_space) begin
                           space_run_odd_in = !space_run_odd_ff;
                        end else begin
                           xor_committed_in = xor_committed_ff ^ q_item.data ^
                              (space_run_odd_ff ? gclcr_pkg::CH_SPACE : 8'd0);
                           space_run_odd_in = 1'b0;
                        end
                     end

                     num_phase_in = num_arm ? gclcr_pkg::DEC_SKIP : num_ctl.phase;
                     num_neg_in   = num_neg_ff || num_ctl.set_neg;
                     if (num_ctl.accum) begin
                        num_acc_in = (num_acc_ff << 3) + (num_acc_ff << 1) + {28'd0, digit};
                     end

                     code_phase_in = code_arm ? gclcr_pkg::DEC_SKIP : code_ctl.phase;
                     code_neg_in   = code_neg_ff || code_ctl.set_neg;
                     if (code_ctl.accum) begin
                        code_acc_in = (code_acc_ff << 3) + (code_acc_ff << 1) + {4'd0, digit};
                     end

                     given_phase_in = given_arm ? gclcr_pkg::DEC_SKIP : given_ctl.phase;
                     given_neg_in   = given_neg_ff || given_ctl.set_neg;
                     if (given_ctl.accum) begin
                        given_acc_in = (given_acc_ff << 3) + (given_acc_ff << 1) +
                                       {4'd0, digit};
                     end
                  end
               end
            end
         end else if (held_count_ff != '0) begin
            line_clear = 1'b1;
            if (!ack_line) begin
               res_fire     = 1'b1;
               res_category = category_ff;
               res_code     = code_val;
               res_number   = num_val;
               if (sum_match) begin
                  res_first    = !any_valid_ff;
                  any_valid_in = 1'b1;
                  if (num_val == last_number_ff) begin
                     res_status = gclcr_pkg::STATUS_DUP;
                  end else if (num_val != expected) begin
                     res_status = gclcr_pkg::STATUS_RESEND;
                     res_number = expected;
                  end else begin
                     res_status     = gclcr_pkg::STATUS_OK;
                     last_number_in = num_val;
                  end
               end else begin
                  res_status = gclcr_pkg::STATUS_CKSUM;
               end
            end
         end
      end

      if (line_clear) begin
         held_count_in    = '0;
         text_ended_in    = 1'b0;
         star_seen_in     = 1'b0;
         xor_committed_in = '0;
         space_run_odd_in = 1'b0;
         vis_cnt_in       = '0;
         first_is_a_in    = 1'b0;
         second_digit_in  = 1'b0;
         sp_seen_in       = 1'b0;
         cat_taken_in     = 1'b0;
         category_in      = '0;
         num_phase_in     = gclcr_pkg::DEC_IDLE;
         num_neg_in       = 1'b0;
         num_acc_in       = '0;
         code_phase_in    = gclcr_pkg::DEC_IDLE;
         code_neg_in      = 1'b0;
         code_acc_in      = '0;
         given_phase_in   = gclcr_pkg::DEC_IDLE;
         given_neg_in     = 1'b0;
         given_acc_in     = '0;
      end
   end

   // output register: a new result loads only when the slot is free or draining
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{gclcr_pkg::RSP_PAD_W{1'b0}}, res_first, res_code, res_category,
                         res_number, res_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff    <= '0;
         text_ended_ff    <= 1'b0;
         star_seen_ff     <= 1'b0;
         xor_committed_ff <= '0;
         space_run_odd_ff <= 1'b0;
         vis_cnt_ff       <= '0;
         first_is_a_ff    <= 1'b0;
         second_digit_ff  <= 1'b0;
         sp_seen_ff       <= 1'b0;
         cat_taken_ff     <= 1'b0;
         category_ff      <= '0;
         num_phase_ff     <= gclcr_pkg::DEC_IDLE;
         num_neg_ff       <= 1'b0;
         num_acc_ff       <= '0;
         code_phase_ff    <= gclcr_pkg::DEC_IDLE;
         code_neg_ff      <= 1'b0;
         code_acc_ff      <= '0;
         given_phase_ff   <= gclcr_pkg::DEC_IDLE;
         given_neg_ff     <= 1'b0;
         given_acc_ff     <= '0;
         last_number_ff   <= '0;
         any_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         held_count_ff    <= held_count_in;
         text_ended_ff    <= text_ended_in;
         star_seen_ff     <= star_seen_in;
         xor_committed_ff <= xor_committed_in;
         space_run_odd_ff <= space_run_odd_in;
         vis_cnt_ff       <= vis_cnt_in;
         first_is_a_ff    <= first_is_a_in;
         second_digit_ff  <= second_digit_in;
         sp_seen_ff       <= sp_seen_in;
         cat_taken_ff     <= cat_taken_in;
         category_ff      <= category_in;
         num_phase_ff     <= num_phase_in;
         num_neg_ff       <= num_neg_in;
         num_acc_ff       <= num_acc_in;
         code_phase_ff    <= code_phase_in;
         code_neg_ff      <= code_neg_in;
         code_acc_ff      <= code_acc_in;
         given_phase_ff   <= given_phase_in;
         given_neg_ff     <= given_neg_in;
         given_acc_ff     <= given_acc_in;
         last_number_ff   <= last_number_in;
         any_valid_ff     <= any_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

/* rtl/gcode_line_checksum_sequence_receiver.sv */
// line receiver for numbered, checksummed g-code text
// req channel: one raw received byte per beat; cr or lf ends a line
// rsp channel: one beat per checked line or per overflow; empty lines and
//   acknowledge lines ("A" plus a digit) give no beat
// the line is parsed as it streams in: line number, category, code, running
//   xor and the decimal checksum after '*' are tracked per byte, so no line
//   buffer is kept and the line end only compares and sequences
// a full line (LINE_BYTES-1 bytes held) turns the next byte into an overflow
//   beat, drops it and clears the line
// result path: with nothing waiting ahead, a line-ending byte accepted on req
//   passes through a queue entry, then the result register, before its
//   result beat is on rsp
// throughput: one byte per cycle while rsp does not stall; the back end retires one queued
//   byte per cycle while the result register is empty or draining
// when rsp stalls, the result register holds and the two-entry queue keeps
//   taking bytes until full, then req_tready drops
// reset clears the line, the queue, the result register, the last accepted
//   line number (0) and the first-valid flag
`default_nettype none
module gcode_line_checksum_sequence_receiver (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [gclcr_pkg::REQ_TDATA_W-1:0] req_tdata,  // [7:0] rx_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [2:0] status, [34:3] line_number, [42:35] category, [50:43] code,
   // [51] first_valid, [55:52] zero
   output logic [gclcr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   gclcr_pkg::byte_class_type push_item;
   gclcr_pkg::byte_class_type pop_item;
   logic                      q_ready;
   logic                      q_push;
   logic                      q_valid;
   logic                      q_pop;

   // front: handshake and byte classification
   gclcr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // short queue decoupling front and back
   gclcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (pop_item)
   );

   // back: line parse, checksum, sequencing and the result register
   gclcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
